// ----- hdl/assert_macros.svh -----
// Assertion macros for the grid index to spherical vertex block.
// Checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GSX_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gsx check failed");
`define GSX_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gsx check failed");
`else
`define GSX_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define GSX_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/gsx_pkg.sv -----
// Shared types, constants and helper functions of the spherical vertex block.
// No dependencies.
package gsx_pkg;

   localparam int DEG_BITS = 25;
   localparam int CW       = 34;

   localparam logic [DEG_BITS-1:0] DEG_FULL = 25'd23592960;
   localparam logic [24:0] DEG_TO_RAD_Q30   = 25'd18740330;
   localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   typedef enum logic [2:0] {
      CSR_RADIUS_MIN,
      CSR_RADIUS_STEP,
      CSR_THETA_MIN,
      CSR_THETA_STEP,
      CSR_PHI_MIN,
      CSR_PHI_STEP,
      CSR_THREE_DIMS
   } csr_index_type;

   typedef struct packed {
      logic signed [CW-1:0] z;
      logic                 flip;
   } angle_type;

   // a + b reduced into one turn; both operands below one turn
   function automatic logic [DEG_BITS-1:0] mod_add(input logic [DEG_BITS-1:0] a,
                                                   input logic [DEG_BITS-1:0] b);
      logic [DEG_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, DEG_FULL}) begin
         s = s - {1'b0, DEG_FULL};
      end
      return s[DEG_BITS-1:0];
   endfunction

   function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] n);
      logic signed [CW-1:0] r;
      case (n)
         5'd0:  r = 34'sd843314856;
         5'd1:  r = 34'sd497837829;
         5'd2:  r = 34'sd263043836;
         5'd3:  r = 34'sd133525158;
         5'd4:  r = 34'sd67021686;
         5'd5:  r = 34'sd33543515;
         5'd6:  r = 34'sd16775850;
         5'd7:  r = 34'sd8388437;
         5'd8:  r = 34'sd4194282;
         5'd9:  r = 34'sd2097149;
         5'd10: r = 34'sd1048575;
         5'd11: r = 34'sd524287;
         5'd12: r = 34'sd262143;
         5'd13: r = 34'sd131071;
         5'd14: r = 34'sd65535;
         5'd15: r = 34'sd32767;
         5'd16: r = 34'sd16383;
         5'd17: r = 34'sd8191;
         5'd18: r = 34'sd4095;
         5'd19: r = 34'sd2047;
         5'd20: r = 34'sd1023;
         5'd21: r = 34'sd511;
         5'd22: r = 34'sd255;
         5'd23: r = 34'sd127;
         5'd24: r = 34'sd63;
         5'd25: r = 34'sd31;
         5'd26: r = 34'sd15;
         5'd27: r = 34'sd7;
         5'd28: r = 34'sd3;
         5'd29: r = 34'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      logic [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'h7fffffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'h80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ----- hdl/gsx_angle.sv -----
// Angle front end: min + step*index reduced to one turn, folded, turned to radians.
// Uses gsx_pkg.
module gsx_angle import gsx_pkg::*; #(
   parameter int INDEX_BITS = 10
) (
   input  logic                       clock,
   input  logic [DEG_BITS-1:0]        step,
   input  logic signed [DEG_BITS-1:0] min_deg,
   input  logic [INDEX_BITS-1:0]      idx,
   output angle_type                  angle_out
);

   localparam logic signed [26:0] FULL_S    = 27'sd23592960;
   localparam logic signed [26:0] HALF_S    = 27'sd11796480;
   localparam logic signed [26:0] QUARTER_S = 27'sd5898240;
   localparam logic signed [26:0] HIGH_S    = 27'sd35389440;

   logic [DEG_BITS-1:0]   acc_ff  [INDEX_BITS];
   logic [DEG_BITS-1:0]   term_ff [INDEX_BITS];
   logic [INDEX_BITS-1:0] idx_ff  [INDEX_BITS];

   // one index bit per stage: acc += step*2^b mod one turn
   for (genvar b = 0; b < INDEX_BITS; b++) begin : g_bit
      logic [DEG_BITS-1:0]   term_in, acc_in, acc_prev;
      logic [INDEX_BITS-1:0] idx_prev;
      if (b == 0) begin : g_first
         assign term_in  = mod_add(step, '0);
         assign acc_prev = '0;
         assign idx_prev = idx;
      end else begin : g_next
         assign term_in  = mod_add(term_ff[b-1], term_ff[b-1]);
         assign acc_prev = acc_ff[b-1];
         assign idx_prev = idx_ff[b-1];
      end
      assign acc_in = idx_prev[b] ? mod_add(acc_prev, term_in) : acc_prev;
      always_ff @(posedge clock) begin
         acc_ff[b]  <= acc_in;
         term_ff[b] <= term_in;
         idx_ff[b]  <= idx_prev;
      end
   end

   logic signed [26:0] sum_w, wrap_in;
   logic signed [26:0] wrap_ff;

   always_comb begin
      sum_w = $signed({2'b00, acc_ff[INDEX_BITS-1]}) + 27'(min_deg);
      if (sum_w >= HIGH_S) begin
         wrap_in = sum_w - FULL_S - FULL_S;
      end else if (sum_w >= HALF_S) begin
         wrap_in = sum_w - FULL_S;
      end else if (sum_w < -HALF_S) begin
         wrap_in = sum_w + FULL_S;
      end else begin
         wrap_in = sum_w;
      end
   end

   always_ff @(posedge clock) begin
      wrap_ff <= wrap_in;
   end

   // fold into [-90, 90]; the fold negates the cosine
   logic signed [26:0] fold_w;
   logic               flip_in;
   logic [22:0]        mag_ff;
   logic               neg_ff, flip1_ff;

   always_comb begin
      flip_in = 1'b1;
      if (wrap_ff > QUARTER_S) begin
         fold_w = HALF_S - wrap_ff;
      end else if (wrap_ff < -QUARTER_S) begin
         fold_w = -HALF_S - wrap_ff;
      end else begin
         fold_w  = wrap_ff;
         flip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff   <= fold_w[26] ? 23'(-fold_w) : fold_w[22:0];
      neg_ff   <= fold_w[26];
      flip1_ff <= flip_in;
   end

   logic [47:0]          prod_w;
   logic signed [CW-1:0] m_w;
   angle_type            out_ff;

   assign prod_w = 48'(mag_ff) * 48'(DEG_TO_RAD_Q30) + 48'd32768;
   assign m_w    = $signed({2'b00, prod_w[47:16]});

   always_ff @(posedge clock) begin
      out_ff.z    <= neg_ff ? -m_w : m_w;
      out_ff.flip <= flip1_ff;
   end

   assign angle_out = out_ff;

endmodule

// ----- hdl/gsx_cordic.sv -----
// Pipelined rotation CORDIC, one iteration per stage, Q2.30 cosine and sine.
// Uses gsx_pkg.
module gsx_cordic import gsx_pkg::*; #(
   parameter int CORDIC_ITERS = 18
) (
   input  logic                 clock,
   input  angle_type            angle_in,
   output logic signed [CW-1:0] cos_out,
   output logic signed [CW-1:0] sin_out
);

   logic signed [CW-1:0] x_ff [CORDIC_ITERS];
   logic signed [CW-1:0] y_ff [CORDIC_ITERS];
   logic signed [CW-1:0] z_ff [CORDIC_ITERS];
   logic                 f_ff [CORDIC_ITERS];

   for (genvar s = 0; s < CORDIC_ITERS; s++) begin : g_iter
      logic signed [CW-1:0] xp, yp, zp, dx, dy, at;
      logic                 fp;
      if (s == 0) begin : g_first
         assign xp = CORDIC_GAIN_Q30;
         assign yp = '0;
         assign zp = angle_in.z;
         assign fp = angle_in.flip;
      end else begin : g_next
         assign xp = x_ff[s-1];
         assign yp = y_ff[s-1];
         assign zp = z_ff[s-1];
         assign fp = f_ff[s-1];
      end
      assign dx = yp >>> s;
      assign dy = xp >>> s;
      assign at = atan_q30(5'(s));
      always_ff @(posedge clock) begin
         if (!zp[CW-1]) begin
            x_ff[s] <= xp - dx;
            y_ff[s] <= yp + dy;
            z_ff[s] <= zp - at;
         end else begin
            x_ff[s] <= xp + dx;
            y_ff[s] <= yp - dy;
            z_ff[s] <= zp + at;
         end
         f_ff[s] <= fp;
      end
   end

   logic signed [CW-1:0] cos_ff, sin_ff;

   always_ff @(posedge clock) begin
      cos_ff <= f_ff[CORDIC_ITERS-1] ? -x_ff[CORDIC_ITERS-1] : x_ff[CORDIC_ITERS-1];
      sin_ff <= y_ff[CORDIC_ITERS-1];
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

// ----- hdl/gsx_mulq30.sv -----
// Three-stage signed length times Q2.30 multiply, rounded half away from zero.
// Uses gsx_pkg for the coefficient width.
module gsx_mulq30 import gsx_pkg::*; #(
   parameter int AW = 41
) (
   input  logic                 clock,
   input  logic signed [AW:0]   a,
   input  logic signed [CW-1:0] c,
   output logic signed [AW+3:0] p
);

   localparam int AM  = AW + 1;
   localparam int LOW = (AM + 1) / 2;
   localparam int HIW = AM - LOW;
   localparam int SW  = AM + 33;
   localparam logic [SW-1:0] ROUND = SW'(1) << 29;

   logic [AM-1:0] amag;
   logic [31:0]   cmag;

   assign amag = a[AW] ? AM'(-a) : AM'(a);
   assign cmag = c[CW-1] ? 32'(-c) : 32'(c);

   // split the wide operand into two partial products
   logic [LOW+31:0] lo_ff;
   logic [HIW+31:0] hi_ff;
   logic            neg1_ff, neg2_ff;
   logic [SW-1:0]   sum_ff;
   logic signed [AW+3:0] p_ff;

   always_ff @(posedge clock) begin
      lo_ff   <= (LOW+32)'(amag[LOW-1:0]) * (LOW+32)'(cmag);
      hi_ff   <= (HIW+32)'(amag[AM-1:LOW]) * (HIW+32)'(cmag);
      neg1_ff <= a[AW] ^ c[CW-1];
      sum_ff  <= (SW'(hi_ff) << LOW) + SW'(lo_ff) + ROUND;
      neg2_ff <= neg1_ff;
      p_ff    <= neg2_ff ? -$signed(sum_ff[SW-1:30]) : $signed(sum_ff[SW-1:30]);
   end

   assign p = p_ff;

endmodule

// ----- hdl/grid_index_to_spherical_xyz.sv -----
// Top level: grid indices in, saturated Q16.16 vertex out; config registers.
// Uses gsx_pkg, gsx_angle, gsx_cordic, gsx_mulq30 and assert_macros.svh.
//
//   channel | ports                              | handshake
//   request | req_i/j/k_index                    | start while busy low
//   result  | rsp_x/y/z_coord                    | rsp_valid, one cycle
//   config  | csr_write_en, csr_index, csr_wdata | write enable only
//
// One word enters every cycle; busy stays low.
// The path from start to rsp_valid runs through the bit-serial angle reduction, the CORDIC
// stages and two three-stage multiplies.
// Synchronous reset clears the valid chain and sets the config registers to their defaults.
// The receiver cannot stall, so the pipeline never holds.
`include "assert_macros.svh"
module grid_index_to_spherical_xyz import gsx_pkg::*; #(
   parameter int INDEX_BITS   = 10,
   parameter int CORDIC_ITERS = 18
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [9:0]  req_i_index,
   input  logic [9:0]  req_j_index,
   input  logic [9:0]  req_k_index,
   output logic        rsp_valid,
   output logic [31:0] rsp_x_coord,
   output logic [31:0] rsp_y_coord,
   output logic [31:0] rsp_z_coord,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [30:0] csr_wdata
);

   localparam int RW  = 31 + INDEX_BITS;
   localparam int SC  = INDEX_BITS + CORDIC_ITERS + 4;
   localparam int LAT = SC + 7;

   // config registers
   logic [30:0]          radius_min_ff, radius_step_ff;
   logic signed [24:0]   theta_min_ff;
   logic [24:0]          theta_step_ff;
   logic signed [23:0]   phi_min_ff;
   logic [23:0]          phi_step_ff;
   logic                 three_dims_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_min_ff  <= 31'd65536;
         radius_step_ff <= '0;
         theta_min_ff   <= -25'sd11796480;
         theta_step_ff  <= '0;
         phi_min_ff     <= '0;
         phi_step_ff    <= '0;
         three_dims_ff  <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_RADIUS_MIN:  radius_min_ff  <= csr_wdata;
            CSR_RADIUS_STEP: radius_step_ff <= csr_wdata;
            CSR_THETA_MIN:   theta_min_ff   <= $signed(csr_wdata[24:0]);
            CSR_THETA_STEP:  theta_step_ff  <= csr_wdata[24:0];
            CSR_PHI_MIN:     phi_min_ff     <= $signed(csr_wdata[23:0]);
            CSR_PHI_STEP:    phi_step_ff    <= csr_wdata[23:0];
            CSR_THREE_DIMS:  three_dims_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // valid chain, stage 0 is the input register
   logic [LAT:0] vld_ff, vld_in;
   assign vld_in = {vld_ff[LAT-1:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   logic [INDEX_BITS-1:0] i_ff, j_ff, k_ff;

   always_ff @(posedge clock) begin
      i_ff <= INDEX_BITS'(req_i_index);
      j_ff <= INDEX_BITS'(req_j_index);
      k_ff <= INDEX_BITS'(req_k_index);
   end

   // radius, then delay to meet the trig values
   logic [RW-1:0] rad_ff [1:SC];

   always_ff @(posedge clock) begin
      rad_ff[1] <= RW'(radius_min_ff) + RW'(radius_step_ff) * RW'(i_ff);
      for (int s = 2; s <= SC; s++) begin
         rad_ff[s] <= rad_ff[s-1];
      end
   end

   angle_type theta_ang, phi_ang;

   gsx_angle #(.INDEX_BITS(INDEX_BITS)) u_theta_angle (
      .clock     (clock),
      .step      (theta_step_ff),
      .min_deg   (theta_min_ff),
      .idx       (j_ff),
      .angle_out (theta_ang)
   );

   gsx_angle #(.INDEX_BITS(INDEX_BITS)) u_phi_angle (
      .clock     (clock),
      .step      ({1'b0, phi_step_ff}),
      .min_deg   (25'(phi_min_ff)),
      .idx       (k_ff),
      .angle_out (phi_ang)
   );

   logic signed [CW-1:0] ct, st, cp, sp;

   gsx_cordic #(.CORDIC_ITERS(CORDIC_ITERS)) u_theta_cordic (
      .clock    (clock),
      .angle_in (theta_ang),
      .cos_out  (ct),
      .sin_out  (st)
   );

   gsx_cordic #(.CORDIC_ITERS(CORDIC_ITERS)) u_phi_cordic (
      .clock    (clock),
      .angle_in (phi_ang),
      .cos_out  (cp),
      .sin_out  (sp)
   );

   // first multiply layer
   logic signed [RW:0]   r_s;
   logic signed [CW-1:0] y_coef;
   logic signed [RW+3:0] rc_w, y_w, x2_w;

   assign r_s    = $signed({1'b0, rad_ff[SC]});
   assign y_coef = three_dims_ff ? sp : st;

   gsx_mulq30 #(.AW(RW)) u_mul_rc (.clock(clock), .a(r_s), .c(cp),     .p(rc_w));
   gsx_mulq30 #(.AW(RW)) u_mul_y  (.clock(clock), .a(r_s), .c(y_coef), .p(y_w));
   gsx_mulq30 #(.AW(RW)) u_mul_x2 (.clock(clock), .a(r_s), .c(ct),     .p(x2_w));

   // hold theta values and 2-D results for the second layer
   logic signed [CW-1:0] ct_ff [3];
   logic signed [CW-1:0] st_ff [3];
   logic signed [RW+3:0] y_ff  [3];
   logic signed [RW+3:0] x2_ff [3];

   always_ff @(posedge clock) begin
      ct_ff[0] <= ct;
      st_ff[0] <= st;
      y_ff[0]  <= y_w;
      x2_ff[0] <= x2_w;
      for (int s = 1; s < 3; s++) begin
         ct_ff[s] <= ct_ff[s-1];
         st_ff[s] <= st_ff[s-1];
         y_ff[s]  <= y_ff[s-1];
         x2_ff[s] <= x2_ff[s-1];
      end
   end

   logic signed [RW+6:0] x3_w, z3_w;

   gsx_mulq30 #(.AW(RW+3)) u_mul_x3 (.clock(clock), .a(rc_w), .c(ct_ff[2]), .p(x3_w));
   gsx_mulq30 #(.AW(RW+3)) u_mul_z3 (.clock(clock), .a(rc_w), .c(st_ff[2]), .p(z3_w));

   logic signed [RW+6:0] x_sel, y_sel, z_sel;
   logic [31:0]          x_ff, y_out_ff, z_ff;

   assign x_sel = three_dims_ff ? x3_w : (RW+7)'(x2_ff[2]);
   assign y_sel = (RW+7)'(y_ff[2]);
   assign z_sel = three_dims_ff ? -z3_w : '0;

   always_ff @(posedge clock) begin
      x_ff     <= sat32(64'(x_sel));
      y_out_ff <= sat32(64'(y_sel));
      z_ff     <= sat32(64'(z_sel));
   end

   assign rsp_valid   = vld_ff[LAT];
   assign rsp_x_coord = x_ff;
   assign rsp_y_coord = y_out_ff;
   assign rsp_z_coord = z_ff;

   `GSX_ASSERT_IMPL(a_z_zero_2d, clock, reset, rsp_valid && !three_dims_ff, rsp_z_coord == 32'd0)
   `GSX_ASSERT_IMPL(a_resp_from_req, clock, reset, rsp_valid, $past(accept, LAT + 1))
   `GSX_ASSERT_NEXT(a_req_enters, clock, reset, accept, vld_ff[0])

endmodule
